### sv/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared widths, register indexes and reset values of the LRU cache lookup.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int LINES_DEF    = 1024;
    localparam int MAX_WAYS_DEF = 8;

    localparam int ADDR_W    = 32;
    localparam int STAMP_W   = 32;
    localparam int TAG_W     = 32;
    localparam int SET_W     = 15;  // index_bits can reach 15
    localparam int OUT_WAY_W = 3;
    localparam int OUT_W     = 40;  // hit, way_used, access_number, padded to bytes

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

    localparam logic [4:0] OFFSET_BITS_RST = 5'd5;
    localparam logic [3:0] INDEX_BITS_RST  = 4'd10;
    localparam logic [3:0] WAYS_RST        = 4'd1;

    localparam logic [STAMP_W-1:0] COUNT_RST = 32'd1;
    localparam logic [STAMP_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    // line entry: {valid, tag, stamp}
    localparam int ENTRY_W = 1 + TAG_W + STAMP_W;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b000_0001,
        S_IDLE  = 7'b000_0010,
        S_MUL   = 7'b000_0100,
        S_QUO   = 7'b000_1000,
        S_RED   = 7'b001_0000,
        S_SCAN  = 7'b010_0000,
        S_WB    = 7'b100_0000
    } t_state;

endpackage

### sv/sacl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram
// Simple dual-port RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/set_assoc_cache_lru_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_core
// Set-associative cache tag lookup with LRU replacement, one address per word.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one 32-bit byte address per word. Master stream: one
//   result per address (hit flag, way that hit or was filled, one-based
//   access number). Config channel writes offset_bits (0), index_bits (1)
//   and ways (2); it is always ready but must only be used while idle.
// Timing:
//   An address is accepted only in idle and runs through three steps that
//   form the line address (multiply, reciprocal multiply, remainder), a
//   scan of the set through the single read port of the line RAM, one read
//   per effective way plus its read latency, and one write-back; the next
//   address is accepted only after the write-back.
// Reset:
//   Registers return to their reset values and a clearing pass writes zero
//   to every line, during which no address is accepted.
// Stalls:
//   The result sits in an output register; the next address is accepted
//   and processed while it waits. Write-back holds until the register frees.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_core #(
    parameter int LINES    = sacl_pkg::LINES_DEF,
    parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream: [31:0] address
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [sacl_pkg::ADDR_W-1:0]     i_s_axis_tdata,
    // master stream: [0] hit, [3:1] way_used, [35:4] access_number, [39:36] zero
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [sacl_pkg::OUT_W-1:0]      o_m_axis_tdata,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LINE_AW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int PW      = sacl_pkg::SET_W + WCNT_W;
    // exact floor(p / LINES) for p < 2**PW as (p * RECIP) >> RSH
    localparam int RSH     = PW + $clog2(LINES);
    localparam logic [PW:0] RECIP =
        (PW+1)'(((64'd1 << RSH) + 64'(LINES) - 64'd1) / 64'(LINES));
    localparam int QW      = 2 * PW + 1;
    localparam int MW      = PW + LINE_AW + 2;

    localparam int TAG_W   = sacl_pkg::TAG_W;
    localparam int STAMP_W = sacl_pkg::STAMP_W;

    sacl_pkg::t_state r_state;

    logic [4:0]         r_offset_bits;
    logic [3:0]         r_index_bits;
    logic [3:0]         r_ways;

    logic [sacl_pkg::ADDR_W-1:0] r_addr;
    logic [TAG_W-1:0]   r_tag;
    logic [WCNT_W-1:0]  r_w;
    logic [PW-1:0]      r_prod;
    logic [PW-1:0]      r_quo;
    logic [STAMP_W-1:0] r_count;
    logic [LINE_AW-1:0] r_clr_addr;

    // scan
    logic [LINE_AW-1:0] r_rd_line;
    logic [WCNT_W-1:0]  r_iss;
    logic               r_chk_v;
    logic [WAY_W-1:0]   r_chk_way;
    logic [LINE_AW-1:0] r_chk_line;

    logic               r_hit_found;
    logic [WAY_W-1:0]   r_hit_way;
    logic [LINE_AW-1:0] r_hit_line;
    logic               r_zero_found;
    logic [WAY_W-1:0]   r_zero_way;
    logic [LINE_AW-1:0] r_zero_line;
    logic               r_min_found;
    logic [STAMP_W-1:0] r_min_stamp;
    logic [WAY_W-1:0]   r_min_way;
    logic [LINE_AW-1:0] r_min_line;

    logic                          r_out_valid;
    logic                          r_out_hit;
    logic [sacl_pkg::OUT_WAY_W-1:0] r_out_way;
    logic [STAMP_W-1:0]            r_out_num;

    // ---- combinational helpers ----
    logic [4:0]              eff_ways;
    logic [sacl_pkg::SET_W-1:0] set_c;
    logic [sacl_pkg::SET_W-1:0] set_mask;
    logic [5:0]              tag_sh;
    logic [TAG_W-1:0]        tag_c;
    logic [QW-1:0]           quo_full;
    logic [MW-1:0]           qmul;
    logic [LINE_AW-1:0]      n_base_line;

    logic                    ram_we;
    logic [LINE_AW-1:0]      ram_waddr;
    logic [sacl_pkg::ENTRY_W-1:0] ram_wdata;
    logic [sacl_pkg::ENTRY_W-1:0] ram_rdata;

    logic                    rd_valid;
    logic [TAG_W-1:0]        rd_tag;
    logic [STAMP_W-1:0]      rd_stamp;

    logic                    out_free;
    logic                    wb_go;
    logic                    n_hit;
    logic [WAY_W-1:0]        n_way;
    logic [LINE_AW-1:0]      n_line;

    function automatic logic [LINE_AW-1:0] next_line(input logic [LINE_AW-1:0] l);
        logic [LINE_AW-1:0] res;
        if (l == LINE_AW'(LINES - 1)) begin
            res = '0;
        end else begin
            res = l + 1'b1;
        end
        return res;
    endfunction

    always_comb begin
        if (r_ways == 4'd0) begin
            eff_ways = 5'd1;
        end else if ({1'b0, r_ways} > 5'(MAX_WAYS)) begin
            eff_ways = 5'(MAX_WAYS);
        end else begin
            eff_ways = {1'b0, r_ways};
        end
    end

    assign set_mask = sacl_pkg::SET_W'((16'd1 << r_index_bits) - 16'd1);
    assign set_c    = sacl_pkg::SET_W'(r_addr >> r_offset_bits) & set_mask;
    assign tag_sh   = {1'b0, r_offset_bits} + {2'b00, r_index_bits};
    assign tag_c    = (tag_sh >= 6'd32) ? '0 : (r_addr >> tag_sh[4:0]);

    assign quo_full    = QW'(r_prod) * QW'(RECIP);
    assign qmul        = MW'(r_quo) * MW'(LINES);
    assign n_base_line = LINE_AW'(r_prod - qmul[PW-1:0]);

    assign rd_valid = ram_rdata[sacl_pkg::ENTRY_W-1];
    assign rd_tag   = ram_rdata[STAMP_W +: TAG_W];
    assign rd_stamp = ram_rdata[STAMP_W-1:0];

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign wb_go    = (r_state == sacl_pkg::S_WB) && out_free;

    // hit beats a never-used way, which beats the oldest stamp
    always_comb begin
        n_hit = r_hit_found;
        if (r_hit_found) begin
            n_way  = r_hit_way;
            n_line = r_hit_line;
        end else if (r_zero_found) begin
            n_way  = r_zero_way;
            n_line = r_zero_line;
        end else begin
            n_way  = r_min_way;
            n_line = r_min_line;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = n_line;
        ram_wdata = {1'b1, r_tag, r_count};
        if (r_state == sacl_pkg::S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (wb_go) begin
            ram_we = 1'b1;
        end
    end

    sacl_ram #(
        .WIDTH (sacl_pkg::ENTRY_W),
        .DEPTH (LINES),
        .AW    (LINE_AW)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_line),
        .o_rdata (ram_rdata)
    );

    // ---- config ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= sacl_pkg::OFFSET_BITS_RST;
            r_index_bits  <= sacl_pkg::INDEX_BITS_RST;
            r_ways        <= sacl_pkg::WAYS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sacl_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                sacl_pkg::CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data[3:0];
                sacl_pkg::CFG_WAYS:        r_ways        <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---- control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sacl_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= sacl_pkg::COUNT_RST;
            r_out_valid <= 1'b0;
            r_chk_v     <= 1'b0;
        end else begin
            if (wb_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                sacl_pkg::S_CLEAR: begin
                    r_clr_addr <= next_line(r_clr_addr);
                    if (r_clr_addr == LINE_AW'(LINES - 1)) begin
                        r_state <= sacl_pkg::S_IDLE;
                    end
                end
                sacl_pkg::S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_state <= sacl_pkg::S_MUL;
                    end
                end
                sacl_pkg::S_MUL: begin
                    r_state <= sacl_pkg::S_QUO;
                end
                sacl_pkg::S_QUO: begin
                    r_state <= sacl_pkg::S_RED;
                end
                sacl_pkg::S_RED: begin
                    r_chk_v <= 1'b0;
                    r_state <= sacl_pkg::S_SCAN;
                end
                sacl_pkg::S_SCAN: begin
                    r_chk_v <= (r_iss != r_w);
                    // last way is being checked this cycle
                    if (r_iss == r_w && r_chk_v) begin
                        r_state <= sacl_pkg::S_WB;
                    end
                end
                sacl_pkg::S_WB: begin
                    if (out_free) begin
                        if (r_count != sacl_pkg::COUNT_MAX) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= sacl_pkg::S_IDLE;
                    end
                end
                default: r_state <= sacl_pkg::S_IDLE;
            endcase
        end
    end

    // ---- datapath ----
    always_ff @(posedge i_clk) begin
        case (r_state)
            sacl_pkg::S_IDLE: begin
                r_addr <= i_s_axis_tdata;
            end
            sacl_pkg::S_MUL: begin
                r_w    <= WCNT_W'(eff_ways);
                r_tag  <= tag_c;
                r_prod <= PW'(set_c) * PW'(eff_ways);
            end
            sacl_pkg::S_QUO: begin
                r_quo <= PW'(quo_full >> RSH);
            end
            sacl_pkg::S_RED: begin
                r_rd_line    <= n_base_line;
                r_iss        <= '0;
                r_hit_found  <= 1'b0;
                r_zero_found <= 1'b0;
                r_min_found  <= 1'b0;
            end
            sacl_pkg::S_SCAN: begin
                if (r_iss != r_w) begin
                    r_rd_line  <= next_line(r_rd_line);
                    r_iss      <= r_iss + 1'b1;
                    r_chk_way  <= WAY_W'(r_iss);
                    r_chk_line <= r_rd_line;
                end
                if (r_chk_v) begin
                    if (!r_hit_found && rd_valid && rd_tag == r_tag) begin
                        r_hit_found <= 1'b1;
                        r_hit_way   <= r_chk_way;
                        r_hit_line  <= r_chk_line;
                    end
                    if (!r_zero_found && rd_stamp == '0) begin
                        r_zero_found <= 1'b1;
                        r_zero_way   <= r_chk_way;
                        r_zero_line  <= r_chk_line;
                    end
                    if (!r_min_found || rd_stamp < r_min_stamp) begin
                        r_min_found <= 1'b1;
                        r_min_stamp <= rd_stamp;
                        r_min_way   <= r_chk_way;
                        r_min_line  <= r_chk_line;
                    end
                end
            end
            default: ;
        endcase
        if (wb_go) begin
            r_out_hit <= n_hit;
            r_out_way <= sacl_pkg::OUT_WAY_W'(n_way);
            r_out_num <= r_count;
        end
    end

    assign o_s_axis_tready = (r_state == sacl_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_num, r_out_way, r_out_hit};

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU cache lookup core.
// A short table of hand-picked accesses and register writes comes first: the
// first rows after reset carry their result typed in, and the rest are scored
// by a behavioural model of the tag store that runs alongside. Random phases
// follow. Each phase sets a new geometry and replays a small pool of block
// addresses, so that hits, fills and LRU evictions all occur. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int N_LINES     = sacl_pkg::LINES_DEF;
    localparam int N_WAYS_MAX  = sacl_pkg::MAX_WAYS_DEF;
    localparam int IDX_W       = sacl_pkg::CFG_IDX_W;
    localparam int CFG_DW      = sacl_pkg::CFG_DATA_W;
    localparam int HALF_PERIOD = 5;
    localparam int STALL_LIMIT = 6000;  // above the clearing pass and the long hold
    localparam int HOLD_CYCLES = 400;
    localparam int N_RANDOM    = 1000;
    localparam int TAIL_CYCLES = 20;    // above the worst-case lookup
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way;
        logic [31:0] num;
    } t_lookup_res;

    typedef enum logic {ROW_ADDR, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                   kind;
        logic [IDX_W-1:0]            idx;
        logic [CFG_DW-1:0]           data;
        logic [sacl_pkg::ADDR_W-1:0] addr;
        bit                          typed;
        logic                        hit;
        logic [2:0]                  way;
    } t_row;

    logic                        i_clk     = 1'b0;
    logic                        i_rst_n   = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [sacl_pkg::ADDR_W-1:0] s_tdata   = '0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [sacl_pkg::OUT_W-1:0]  m_tdata;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [IDX_W-1:0]            cfg_index = '0;
    logic [CFG_DW-1:0]           cfg_data  = '0;

    // typed-in expectation travelling with the word on offer
    bit                    row_typed = 1'b0;
    logic                  row_hit   = 1'b0;
    logic [2:0]            row_way   = '0;

    bit                    hold_req  = 1'b0;
    int                    stall_cycles = 0;
    int                    errors    = 0;
    int                    n_checked = 0;
    int                    n_hits    = 0;
    int                    n_cfg     = 0;
    logic [4:0]            drv_offset = sacl_pkg::OFFSET_BITS_RST;

    always #HALF_PERIOD i_clk = ~i_clk;

    set_assoc_cache_lru_lookup_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Tag store model
    // ------------------------------------------------------------------------
    bit          line_valid [N_LINES];
    logic [31:0] line_tag   [N_LINES];
    logic [31:0] line_stamp [N_LINES];
    logic [31:0] access_cnt      = sacl_pkg::COUNT_RST;
    logic [4:0]  cur_offset_bits = sacl_pkg::OFFSET_BITS_RST;
    logic [3:0]  cur_index_bits  = sacl_pkg::INDEX_BITS_RST;
    logic [3:0]  cur_ways        = sacl_pkg::WAYS_RST;

    initial begin
        foreach (line_valid[i]) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_stamp[i] = '0;
        end
    end

    function automatic t_lookup_res lru_lookup(input logic [31:0] addr);
        t_lookup_res r;
        int unsigned w, set_no, shamt, tag, ln, best, pick, k;
        bit          found, hit;
        w = (cur_ways == 0) ? 1 : (cur_ways > N_WAYS_MAX) ? N_WAYS_MAX : cur_ways;
        set_no = (addr >> cur_offset_bits) & ((32'd1 << cur_index_bits) - 32'd1);
        shamt  = cur_offset_bits + cur_index_bits;
        tag    = (shamt >= 32) ? 0 : (addr >> shamt);
        hit    = 1'b0;
        pick   = 0;
        // sets may alias onto the same lines once sets * ways passes the store
        for (k = 0; k < w; k++) begin
            ln = (set_no * w + k) % N_LINES;
            if (line_valid[ln] && line_tag[ln] == tag) begin
                hit = 1'b1;
                pick = k;
                line_stamp[ln] = access_cnt;
                break;
            end
        end
        if (!hit) begin
            found = 1'b0;
            best  = 0;
            // first never-used way wins, else oldest stamp, lowest way on a tie
            for (k = 0; k < w; k++) begin
                ln = (set_no * w + k) % N_LINES;
                if (line_stamp[ln] == 0) begin
                    pick = k;
                    break;
                end
                if (!found || line_stamp[ln] < best) begin
                    found = 1'b1;
                    best  = line_stamp[ln];
                    pick  = k;
                end
            end
            ln = (set_no * w + pick) % N_LINES;
            line_valid[ln] = 1'b1;
            line_tag[ln]   = tag;
            line_stamp[ln] = access_cnt;
        end
        r.hit = hit;
        r.way = pick[2:0];
        r.num = access_cnt;
        if (access_cnt != sacl_pkg::COUNT_MAX) access_cnt++;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: scores results, predicts on accepted addresses, tracks config
    // ------------------------------------------------------------------------
    t_lookup_res lookup_q [$];

    task automatic note_fail(input string msg);
        errors++;
        if (errors <= 10) $display("MISMATCH: %s", msg);
    endtask

    always @(posedge i_clk) begin
        t_lookup_res got, want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got.hit = m_tdata[0];
                got.way = m_tdata[3:1];
                got.num = m_tdata[35:4];
                if (lookup_q.size() == 0) begin
                    note_fail($sformatf("unexpected result hit %0b way %0d num %0d",
                                        got.hit, got.way, got.num));
                end else begin
                    want = lookup_q.pop_front();
                    n_checked++;
                    n_hits += want.hit;
                    if (got.hit !== want.hit || got.way !== want.way || got.num !== want.num)
                        note_fail($sformatf(
                            "exp hit %0b way %0d num %0d, got hit %0b way %0d num %0d",
                            want.hit, want.way, want.num, got.hit, got.way, got.num));
                end
            end
            if (s_tvalid && s_tready) begin
                want = lru_lookup(s_tdata);
                if (row_typed) begin
                    want.hit = row_hit;
                    want.way = row_way;
                end
                lookup_q.insert(lookup_q.size(), want);
            end
            if (cfg_valid && cfg_ready) begin
                n_cfg++;
                case (cfg_index)
                    sacl_pkg::CFG_OFFSET_BITS: cur_offset_bits = cfg_data[4:0];
                    sacl_pkg::CFG_INDEX_BITS:  cur_index_bits  = cfg_data[3:0];
                    sacl_pkg::CFG_WAYS:        cur_ways        = cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog on cycles without any accepted word
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("timeout after %0d idle cycles", stall_cycles);
        $display("tb failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, ready-only stretches, one long hold
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        int free_run;
        gap      = 0;
        free_run = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (free_run > 0) begin
                free_run--;
                m_tready <= 1'b1;
            end else if (gap > 0) begin
                gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(29) == 0) free_run = $urandom_range(20, 80);
                else gap = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Address side
    // ------------------------------------------------------------------------
    task automatic send_addr(input logic [31:0] a, input int gap, input bit typed,
                             input logic hit, input logic [2:0] way);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= a;
        row_typed <= typed;
        row_hit   <= hit;
        row_way   <= way;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (lookup_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        if (idx == sacl_pkg::CFG_OFFSET_BITS) drv_offset = val;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_row addr_row(input logic [31:0] a, input bit typed,
                                      input logic hit, input logic [2:0] way);
        t_row r;
        r.kind  = ROW_ADDR;
        r.idx   = '0;
        r.data  = '0;
        r.addr  = a;
        r.typed = typed;
        r.hit   = hit;
        r.way   = way;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [IDX_W-1:0] idx,
                                     input logic [CFG_DW-1:0] val);
        t_row r;
        r       = addr_row('0, 1'b0, 1'b0, '0);
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = val;
        return r;
    endfunction

    initial begin
        t_row        rows [$];
        logic [31:0] pool [12];
        logic [31:0] a;
        logic [31:0] low_mask;
        int          n_items, phase, phase_len, psize, gap;
        bit          hold_phase;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: 32-byte blocks, 1024 sets, direct mapped
        rows.insert(rows.size(), addr_row(32'h0000_0000, 1'b1, 1'b0, 3'd0));
        rows.insert(rows.size(), addr_row(32'h0000_0000, 1'b1, 1'b1, 3'd0));
        rows.insert(rows.size(), addr_row(32'hFFFF_FFFF, 1'b1, 1'b0, 3'd0));
        rows.insert(rows.size(), addr_row(32'hFFFF_FFE0, 1'b1, 1'b1, 3'd0));
        // evicts set 0
        rows.insert(rows.size(), addr_row(32'h0000_8000, 1'b1, 1'b0, 3'd0));
        rows.insert(rows.size(), addr_row(32'h0000_0000, 1'b1, 1'b0, 3'd0));
        // 4-way, 4 sets, stores kept across the change
        rows.insert(rows.size(), cfg_row(sacl_pkg::CFG_WAYS, 5'd4));
        rows.insert(rows.size(), cfg_row(sacl_pkg::CFG_INDEX_BITS, 5'd2));
        rows.insert(rows.size(), cfg_row(sacl_pkg::CFG_OFFSET_BITS, 5'd4));
        rows.insert(rows.size(), addr_row(32'h0000_0000, 1'b0, 1'b0, 3'd0));
        rows.insert(rows.size(), addr_row(32'h0000_0040, 1'b0, 1'b0, 3'd0));
        rows.insert(rows.size(), addr_row(32'h0000_0080, 1'b0, 1'b0, 3'd0));
        rows.insert(rows.size(), addr_row(32'h0000_00C0, 1'b0, 1'b0, 3'd0));
        // LRU victim
        rows.insert(rows.size(), addr_row(32'h0000_0100, 1'b0, 1'b0, 3'd0));
        rows.insert(rows.size(), addr_row(32'h0000_0000, 1'b0, 1'b0, 3'd0));
        // zero ways acts as one
        rows.insert(rows.size(), cfg_row(sacl_pkg::CFG_WAYS, 5'd0));
        rows.insert(rows.size(), addr_row(32'h1234_5678, 1'b0, 1'b0, 3'd0));
        // ways clamp, widest offset, index past range: tag shift beyond 31
        rows.insert(rows.size(), cfg_row(sacl_pkg::CFG_WAYS, 5'h1F));
        rows.insert(rows.size(), cfg_row(sacl_pkg::CFG_OFFSET_BITS, 5'h1F));
        rows.insert(rows.size(), cfg_row(sacl_pkg::CFG_INDEX_BITS, 5'h0F));
        rows.insert(rows.size(), addr_row(32'h8000_0000, 1'b0, 1'b0, 3'd0));
        rows.insert(rows.size(), addr_row(32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0));
        rows.insert(rows.size(), cfg_row(CFG_UNUSED, 5'h15));
        rows.insert(rows.size(), cfg_row(sacl_pkg::CFG_OFFSET_BITS, 5'd0));
        // upper bit dropped: one set
        rows.insert(rows.size(), cfg_row(sacl_pkg::CFG_INDEX_BITS, 5'h10));
        rows.insert(rows.size(), addr_row(32'hAAAA_AAAA, 1'b0, 1'b0, 3'd0));
        rows.insert(rows.size(), addr_row(32'h5555_5555, 1'b0, 1'b0, 3'd0));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                drain();
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                send_addr(rows[i].addr, pick_gap(), rows[i].typed, rows[i].hit, rows[i].way);
            end
        end

        n_items = 0;
        phase   = 0;
        while (n_items < N_RANDOM) begin
            drain();
            case (phase)
                0: begin  // one fully associative set of eight
                    write_reg(sacl_pkg::CFG_OFFSET_BITS, 5'd2);
                    write_reg(sacl_pkg::CFG_INDEX_BITS, 5'd0);
                    write_reg(sacl_pkg::CFG_WAYS, 5'd8);
                end
                1: begin  // direct mapped, widest offset
                    write_reg(sacl_pkg::CFG_OFFSET_BITS, 5'd31);
                    write_reg(sacl_pkg::CFG_INDEX_BITS, 5'd10);
                    write_reg(sacl_pkg::CFG_WAYS, 5'd1);
                end
                2: begin  // 1024 sets of 8: lines alias
                    write_reg(sacl_pkg::CFG_OFFSET_BITS, 5'd4);
                    write_reg(sacl_pkg::CFG_INDEX_BITS, 5'd10);
                    write_reg(sacl_pkg::CFG_WAYS, 5'd8);
                end
                default: begin
                    if ($urandom_range(3) == 0) begin
                        // change one register only
                        case ($urandom_range(2))
                            0: write_reg(sacl_pkg::CFG_OFFSET_BITS,
                                         CFG_DW'($urandom_range(0, 31)));
                            1: write_reg(sacl_pkg::CFG_INDEX_BITS,
                                         CFG_DW'($urandom_range(0, 31)));
                            default: write_reg(sacl_pkg::CFG_WAYS,
                                               CFG_DW'($urandom_range(0, 31)));
                        endcase
                    end else begin
                        write_reg(sacl_pkg::CFG_OFFSET_BITS, CFG_DW'(($urandom_range(9) < 7) ?
                                  $urandom_range(2, 8) : $urandom_range(0, 31)));
                        write_reg(sacl_pkg::CFG_INDEX_BITS, CFG_DW'(($urandom_range(3) < 3) ?
                                  $urandom_range(0, 6) : $urandom_range(0, 31)));
                        write_reg(sacl_pkg::CFG_WAYS, CFG_DW'(($urandom_range(9) < 7) ?
                                  $urandom_range(1, 8) : $urandom_range(0, 31)));
                    end
                end
            endcase

            // small working set of blocks, replayed with random byte offsets
            psize = $urandom_range(2, 12);
            foreach (pool[k]) pool[k] = $urandom;
            low_mask   = (32'd1 << drv_offset) - 32'd1;
            phase_len  = $urandom_range(30, 90);
            hold_phase = (phase == 4);
            if (hold_phase) hold_req = 1'b1;

            for (int j = 0; j < phase_len; j++) begin
                if ($urandom_range(99) < 80)
                    a = pool[$urandom_range(psize - 1)] ^ ($urandom & low_mask);
                else
                    a = $urandom;
                gap = hold_phase ? 0 : pick_gap();
                send_addr(a, gap, 1'b0, 1'b0, 3'd0);
                n_items++;
            end
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        errors += lookup_q.size();
        $display("%0d lookups scored, %0d hits, over %0d register writes and %0d random phases",
                 n_checked, n_hits, n_cfg, phase);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/sacl_pkg.sv
sv/sacl_ram.sv
sv/set_assoc_cache_lru_lookup_core.sv
sim/tb.sv
